>>> hdl/ftpd_pkg.sv
`timescale 1ns / 1ps
package ftpd_pkg;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_OP_HI   = 4'd0;
  localparam logic [PhaseW-1:0] PH_OP_LO   = 4'd1;
  localparam logic [PhaseW-1:0] PH_ACK_HI  = 4'd2;
  localparam logic [PhaseW-1:0] PH_ACK_LO  = 4'd3;
  localparam logic [PhaseW-1:0] PH_SIZE_HI = 4'd4;
  localparam logic [PhaseW-1:0] PH_SIZE_LO = 4'd5;
  localparam logic [PhaseW-1:0] PH_BLK_HI  = 4'd6;
  localparam logic [PhaseW-1:0] PH_BLK_LO  = 4'd7;
  localparam logic [PhaseW-1:0] PH_DATA    = 4'd8;
  localparam logic [PhaseW-1:0] PH_NAME    = 4'd9;
  localparam logic [PhaseW-1:0] PH_PREFIX  = 4'd10;
  localparam logic [PhaseW-1:0] PH_ABSORB  = 4'd11;

  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;
  localparam logic [15:0] OP_DIRQ  = 16'd6;
  localparam logic [15:0] OP_LOGRQ = 16'd7;
  localparam logic [15:0] OP_DELRQ = 16'd8;
  localparam logic [15:0] OP_BCAST = 16'd9;
  localparam logic [15:0] OP_DISC  = 16'd10;

  localparam logic [7:0] NUL_BYTE = 8'h00;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        packet_done;
    logic [15:0] packet_opcode;
    logic [15:0] block_number;
    logic [15:0] data_size;
    logic [15:0] error_code;
    logic [7:0]  added_flag;
  } ftpd_res_t;

endpackage

>>> hdl/ftpd_ifs.sv
`timescale 1ns / 1ps
interface ftpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface ftpd_res_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        packet_done;
  logic [15:0] packet_opcode;
  logic [15:0] block_number;
  logic [15:0] data_size;
  logic [15:0] error_code;
  logic [7:0]  added_flag;

  modport source (
    output valid, output payload_valid, output payload_byte, output packet_done,
    output packet_opcode, output block_number, output data_size, output error_code,
    output added_flag, input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input packet_done,
    input packet_opcode, input block_number, input data_size, input error_code,
    input added_flag, output ready
  );
endinterface

>>> hdl/file_transfer_packet_deframer_top.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    byte_in
// out_ch    out  valid/ready    payload_valid, payload_byte, packet_done, packet_opcode,
//                               block_number, data_size, error_code, added_flag
//
// One byte is taken per cycle while in_ch.ready is high; results are registered.
// Header and opcode bytes give no result unless ending a packet; results are sparser.
// Reset is synchronous: the parser returns to the opcode high byte, stores clear.
// A two-entry output stage holds results while out_ch stalls; in_ch.ready
// drops only when both entries are full.
module file_transfer_packet_deframer_top (
  input logic         clk,
  input logic         rst_n,
  ftpd_byte_if.sink   in_ch,
  ftpd_res_if.source  out_ch
);
  import ftpd_pkg::*;

  logic      fire;
  logic      res_valid;
  logic      space;
  ftpd_res_t res;
  ftpd_res_t out_data;

  assign in_ch.ready = space;
  assign fire        = in_ch.valid && space;

  ftpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .byte_in   (in_ch.byte_in),
    .res_valid (res_valid),
    .res       (res)
  );

  ftpd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.payload_valid = out_data.payload_valid;
  assign out_ch.payload_byte  = out_data.payload_byte;
  assign out_ch.packet_done   = out_data.packet_done;
  assign out_ch.packet_opcode = out_data.packet_opcode;
  assign out_ch.block_number  = out_data.block_number;
  assign out_ch.data_size     = out_data.data_size;
  assign out_ch.error_code    = out_data.error_code;
  assign out_ch.added_flag    = out_data.added_flag;

endmodule

>>> hdl/ftpd_parser.sv
`timescale 1ns / 1ps
module ftpd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          byte_in,
  output logic                res_valid,
  output ftpd_pkg::ftpd_res_t res
);
  import ftpd_pkg::*;

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [15:0]       opcode_r, opcode_nxt;
  logic [7:0]        hold_r, hold_nxt;
  logic              prefix_r, prefix_nxt;
  logic [15:0]       left_r, left_nxt;
  logic [15:0]       block_r, block_nxt;
  logic [15:0]       size_r, size_nxt;
  logic [15:0]       error_r, error_nxt;
  logic [7:0]        flag_r, flag_nxt;
  logic              emit;
  logic              pv;
  logic              done;
  logic [15:0]       joined;

  assign joined = {hold_r, byte_in};

  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    hold_nxt   = hold_r;
    prefix_nxt = prefix_r;
    left_nxt   = left_r;
    block_nxt  = block_r;
    size_nxt   = size_r;
    error_nxt  = error_r;
    flag_nxt   = flag_r;
    emit       = 1'b0;
    pv         = 1'b0;
    done       = 1'b0;
    case (phase_r)
      PH_OP_HI: begin
        hold_nxt  = byte_in;
        phase_nxt = PH_OP_LO;
      end
      PH_OP_LO: begin
        opcode_nxt = joined;
        block_nxt  = '0;
        size_nxt   = '0;
        error_nxt  = '0;
        flag_nxt   = '0;
        prefix_nxt = 1'b0;
        left_nxt   = '0;
        case (joined)
          OP_DIRQ, OP_DISC: begin
            phase_nxt = PH_OP_HI;
            emit      = 1'b1;
            done      = 1'b1;
          end
          OP_ACK: phase_nxt = PH_ACK_HI;
          OP_DATA: phase_nxt = PH_SIZE_HI;
          OP_RRQ, OP_WRQ, OP_LOGRQ, OP_DELRQ: phase_nxt = PH_NAME;
          OP_ERROR, OP_BCAST: phase_nxt = PH_PREFIX;
          default: phase_nxt = PH_ABSORB;
        endcase
      end
      PH_ACK_HI: begin
        hold_nxt  = byte_in;
        phase_nxt = PH_ACK_LO;
      end
      PH_ACK_LO: begin
        block_nxt = joined;
        phase_nxt = PH_OP_HI;
        emit      = 1'b1;
        done      = 1'b1;
      end
      PH_SIZE_HI: begin
        hold_nxt  = byte_in;
        phase_nxt = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        size_nxt  = joined;
        phase_nxt = PH_BLK_HI;
      end
      PH_BLK_HI: begin
        hold_nxt  = byte_in;
        phase_nxt = PH_BLK_LO;
      end
      PH_BLK_LO: begin
        block_nxt = joined;
        left_nxt  = size_r;
        if (size_r == '0) begin
          phase_nxt = PH_OP_HI;
          emit      = 1'b1;
          done      = 1'b1;
        end else if (size_r[15]) begin
          phase_nxt = PH_ABSORB;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        left_nxt = left_r - 16'd1;
        emit     = 1'b1;
        pv       = 1'b1;
        if (left_nxt == '0) begin
          phase_nxt = PH_OP_HI;
          done      = 1'b1;
        end
      end
      PH_NAME: begin
        emit = 1'b1;
        if (byte_in == NUL_BYTE) begin
          phase_nxt = PH_OP_HI;
          done      = 1'b1;
        end else begin
          pv = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (!prefix_r) begin
          prefix_nxt = 1'b1;
          if (opcode_r == OP_ERROR) begin
            hold_nxt = byte_in;
          end else begin
            flag_nxt = byte_in;
          end
        end else begin
          prefix_nxt = 1'b0;
          phase_nxt  = PH_NAME;
          if (opcode_r == OP_ERROR) begin
            error_nxt = joined;
          end else begin
            emit = 1'b1;
            pv   = 1'b1;
          end
        end
      end
      default: phase_nxt = PH_ABSORB;
    endcase
  end

  assign res_valid         = fire && emit;
  assign res.payload_valid = pv;
  assign res.payload_byte  = pv ? byte_in : NUL_BYTE;
  assign res.packet_done   = done;
  assign res.packet_opcode = opcode_nxt;
  assign res.block_number  = block_nxt;
  assign res.data_size     = size_nxt;
  assign res.error_code    = error_nxt;
  assign res.added_flag    = flag_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OP_HI;
      opcode_r <= '0;
      hold_r   <= '0;
      prefix_r <= 1'b0;
      left_r   <= '0;
      block_r  <= '0;
      size_r   <= '0;
      error_r  <= '0;
      flag_r   <= '0;
    end else if (fire) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      hold_r   <= hold_nxt;
      prefix_r <= prefix_nxt;
      left_r   <= left_nxt;
      block_r  <= block_nxt;
      size_r   <= size_nxt;
      error_r  <= error_nxt;
      flag_r   <= flag_nxt;
    end
  end

endmodule

>>> hdl/ftpd_skid.sv
`timescale 1ns / 1ps
module ftpd_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ftpd_pkg::ftpd_res_t push_data,
  output logic                space,
  output logic                out_valid,
  input  logic                out_ready,
  output ftpd_pkg::ftpd_res_t out_data
);
  import ftpd_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  ftpd_res_t main_r;
  ftpd_res_t skid_r;
  logic      pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push && main_valid_r && !pop) begin
      skid_valid_r <= 1'b1;
    end else if (push) begin
      main_valid_r <= 1'b1;
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push && main_valid_r && !pop) begin
      skid_r <= push_data;
    end else if (push) begin
      main_r <= push_data;
    end
  end

endmodule

>>> hdl/ftpd_checker.sv
`timescale 1ns / 1ps
module ftpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        payload_valid,
  input logic [7:0]  payload_byte,
  input logic        packet_done,
  input logic [15:0] packet_opcode,
  input logic [7:0]  added_flag
);
  import ftpd_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_has_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (payload_valid || packet_done))
    else $error("empty result transfer");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !payload_valid) |-> (payload_byte == NUL_BYTE))
    else $error("payload byte set without payload");

  a_flag_owner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && added_flag != 8'd0) |-> (packet_opcode == OP_BCAST))
    else $error("flag on non-broadcast packet");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(payload_byte)
      && $stable(packet_done) && $stable(packet_opcode)))
    else $error("stalled result changed");

endmodule

bind file_transfer_packet_deframer_top ftpd_checker u_ftpd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .payload_valid (out_ch.payload_valid),
  .payload_byte  (out_ch.payload_byte),
  .packet_done   (out_ch.packet_done),
  .packet_opcode (out_ch.packet_opcode),
  .added_flag    (out_ch.added_flag)
);

>>> verif/tb_file_transfer_packet_deframer_top.sv
`timescale 1ns / 1ps
module tb_file_transfer_packet_deframer_top;
  import ftpd_pkg::*;

  localparam int unsigned CycleLimit   = 500000;
  localparam int unsigned RandomBytes  = 650;
  localparam int unsigned HoldCycles   = 150;
  localparam int unsigned DrainCycles  = 10;

  logic clk;
  logic rst_n;

  ftpd_byte_if in_ch ();
  ftpd_res_if  out_ch ();

  file_transfer_packet_deframer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [PhaseW-1:0] parse_phase;
  logic [15:0]       cur_opcode;
  logic [7:0]        hi_hold;
  logic              prefix_taken;
  logic [15:0]       data_left;
  logic [15:0]       cur_block;
  logic [15:0]       cur_size;
  logic [15:0]       cur_error;
  logic [7:0]        cur_flag;

  ftpd_res_t   due_results[$];
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned cycle_count;
  bit          tx_idle;
  bit          rx_idle;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned rx_gap;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void deframe_byte(input logic [7:0] b);
    ftpd_res_t  r;
    logic       fire;
    logic       pv;
    logic [7:0] pb;
    logic       done;
    fire = 1'b0;
    pv   = 1'b0;
    pb   = 8'h00;
    done = 1'b0;
    case (parse_phase)
      PH_OP_HI: begin
        hi_hold     = b;
        parse_phase = PH_OP_LO;
      end
      PH_OP_LO: begin
        cur_opcode   = {hi_hold, b};
        cur_block    = '0;
        cur_size     = '0;
        cur_error    = '0;
        cur_flag     = '0;
        prefix_taken = 1'b0;
        data_left    = '0;
        case (cur_opcode)
          OP_DIRQ, OP_DISC: begin
            parse_phase = PH_OP_HI;
            fire        = 1'b1;
            done        = 1'b1;
          end
          OP_ACK:                            parse_phase = PH_ACK_HI;
          OP_DATA:                           parse_phase = PH_SIZE_HI;
          OP_RRQ, OP_WRQ, OP_LOGRQ, OP_DELRQ: parse_phase = PH_NAME;
          OP_ERROR, OP_BCAST:                parse_phase = PH_PREFIX;
          default:                           parse_phase = PH_ABSORB;
        endcase
      end
      PH_ACK_HI: begin
        hi_hold     = b;
        parse_phase = PH_ACK_LO;
      end
      PH_ACK_LO: begin
        cur_block   = {hi_hold, b};
        parse_phase = PH_OP_HI;
        fire        = 1'b1;
        done        = 1'b1;
      end
      PH_SIZE_HI: begin
        hi_hold     = b;
        parse_phase = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        cur_size    = {hi_hold, b};
        parse_phase = PH_BLK_HI;
      end
      PH_BLK_HI: begin
        hi_hold     = b;
        parse_phase = PH_BLK_LO;
      end
      PH_BLK_LO: begin
        cur_block = {hi_hold, b};
        data_left = cur_size;
        if (cur_size == 16'd0) begin
          parse_phase = PH_OP_HI;
          fire        = 1'b1;
          done        = 1'b1;
        end else if (cur_size[15]) begin
          parse_phase = PH_ABSORB;
        end else begin
          parse_phase = PH_DATA;
        end
      end
      PH_DATA: begin
        data_left = data_left - 16'd1;
        fire      = 1'b1;
        pv        = 1'b1;
        pb        = b;
        if (data_left == 16'd0) begin
          done        = 1'b1;
          parse_phase = PH_OP_HI;
        end
      end
      PH_NAME: begin
        fire = 1'b1;
        if (b == NUL_BYTE) begin
          done        = 1'b1;
          parse_phase = PH_OP_HI;
        end else begin
          pv = 1'b1;
          pb = b;
        end
      end
      PH_PREFIX: begin
        if (!prefix_taken) begin
          prefix_taken = 1'b1;
          if (cur_opcode == OP_ERROR) hi_hold = b;
          else cur_flag = b;
        end else begin
          prefix_taken = 1'b0;
          parse_phase  = PH_NAME;
          if (cur_opcode == OP_ERROR) begin
            cur_error = {hi_hold, b};
          end else begin
            fire = 1'b1;
            pv   = 1'b1;
            pb   = b;
          end
        end
      end
      default: parse_phase = PH_ABSORB;
    endcase
    if (fire) begin
      r.payload_valid = pv;
      r.payload_byte  = pb;
      r.packet_done   = done;
      r.packet_opcode = cur_opcode;
      r.block_number  = cur_block;
      r.data_size     = cur_size;
      r.error_code    = cur_error;
      r.added_flag    = cur_flag;
      due_results = {due_results, r};
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  always @(posedge clk) begin
    ftpd_res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = due_results.pop_front();
        check_field("payload_valid", 16'(out_ch.payload_valid), 16'(want.payload_valid));
        check_field("payload_byte", 16'(out_ch.payload_byte), 16'(want.payload_byte));
        check_field("packet_done", 16'(out_ch.packet_done), 16'(want.packet_done));
        check_field("packet_opcode", out_ch.packet_opcode, want.packet_opcode);
        check_field("block_number", out_ch.block_number, want.block_number);
        check_field("data_size", out_ch.data_size, want.data_size);
        check_field("error_code", out_ch.error_code, want.error_code);
        check_field("added_flag", 16'(out_ch.added_flag), 16'(want.added_flag));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb_file_transfer_packet_deframer_top: FAIL");
      $finish;
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    rx_gap       = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (rx_gap > 0) begin
        out_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if (rx_idle) rx_gap = pick_gap();
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_idle ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    deframe_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[15:8]);
    send_byte(w[7:0]);
  endtask

  task automatic send_string(input int unsigned len);
    repeat (len) send_byte(8'($urandom_range(1, 255)));
    send_byte(NUL_BYTE);
  endtask

  task automatic send_data(input logic [15:0] size, input logic [15:0] blk);
    send_word(OP_DATA);
    send_word(size);
    send_word(blk);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_bcast(input logic [7:0] flag, input logic [7:0] first,
                            input int unsigned len);
    send_word(OP_BCAST);
    send_byte(flag);
    send_byte(first);
    send_string(len);
  endtask

  function automatic int unsigned rand_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(13, 40);
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [15:0] rand_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 98) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(17, 512));
  endfunction

  task automatic send_random_packet();
    logic [7:0] first;
    first = ($urandom_range(0, 3) == 0) ? NUL_BYTE : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: begin send_word(OP_RRQ);   send_string(rand_len()); end
      1: begin send_word(OP_WRQ);   send_string(rand_len()); end
      2: begin send_word(OP_LOGRQ); send_string(rand_len()); end
      3: begin send_word(OP_DELRQ); send_string(rand_len()); end
      4: send_data(rand_size(), 16'($urandom_range(0, 65535)));
      5: begin
        send_word(OP_ACK);
        send_word(16'($urandom_range(0, 65535)));
      end
      6: begin
        send_word(OP_ERROR);
        send_word(($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(0, 65535)));
        send_string(rand_len());
      end
      7: send_word(OP_DIRQ);
      8: send_word(OP_DISC);
      default: send_bcast(8'($urandom_range(0, 255)), first, rand_len());
    endcase
  endtask

  task automatic test_bare_opcodes();
    send_word(OP_DIRQ);
    send_word(OP_DISC);
  endtask

  task automatic test_ack();
    send_word(OP_ACK);
    send_word(16'h0000);
    send_word(OP_ACK);
    send_word(16'hFFFF);
  endtask

  task automatic test_data();
    send_data(16'd0, 16'hFFFF);
    send_word(OP_DATA);
    send_word(16'd1);
    send_word(16'h0000);
    send_byte(NUL_BYTE);
    send_word(OP_DATA);
    send_word(16'd3);
    send_word(16'h1234);
    send_byte(8'hFF);
    send_byte(NUL_BYTE);
    send_byte(8'h5A);
    send_data(16'd512, 16'($urandom_range(0, 65535)));
  endtask

  task automatic test_requests();
    send_word(OP_RRQ);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h80);
    send_byte(NUL_BYTE);
    send_word(OP_WRQ);
    send_byte(NUL_BYTE);
    send_word(OP_LOGRQ);
    send_string(3);
    send_word(OP_DELRQ);
    send_string(1);
  endtask

  task automatic test_error();
    send_word(OP_ERROR);
    send_word(16'h0000);
    send_byte(NUL_BYTE);
    send_word(OP_ERROR);
    send_word(16'hFFFF);
    send_string(4);
  endtask

  task automatic test_broadcast();
    send_bcast(8'h00, NUL_BYTE, 2);
    send_word(OP_BCAST);
    send_byte(8'hFF);
    send_byte(8'h41);
    send_byte(NUL_BYTE);
    send_bcast(8'h00, NUL_BYTE, 0);
  endtask

  task automatic test_backpressure();
    tx_idle  = 1'b0;
    hold_req = 1'b1;
    send_word(OP_RRQ);
    repeat (40) send_byte(8'($urandom_range(1, 255)));
    send_byte(NUL_BYTE);
    repeat (6) send_word(OP_DISC);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_packets();
    int unsigned stop_at;
    stop_at = bytes_sent + RandomBytes;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 29) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 29) == 0) rx_idle = !rx_idle;
      send_random_packet();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_absorb();
    logic [15:0] bad_op;
    case ($urandom_range(0, 2))
      0: begin
        bad_op = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(11, 65535));
        send_word(bad_op);
      end
      1: begin
        send_word(OP_DATA);
        send_word(16'h8000 | 16'($urandom_range(0, 32767)));
        send_word(16'($urandom_range(0, 65535)));
      end
      default: begin
        send_word(OP_ACK);
        send_byte(8'($urandom_range(0, 255)));
        send_random_packet();
      end
    endcase
    repeat (40) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.byte_in = 8'h00;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    hold_req      = 1'b0;
    mismatches    = 0;
    bytes_sent    = 0;
    cycle_count   = 0;
    parse_phase   = PH_OP_HI;
    cur_opcode    = '0;
    hi_hold       = '0;
    prefix_taken  = 1'b0;
    data_left     = '0;
    cur_block     = '0;
    cur_size      = '0;
    cur_error     = '0;
    cur_flag      = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_bare_opcodes();
    test_ack();
    test_data();
    test_requests();
    test_error();
    test_broadcast();
    test_backpressure();
    test_random_packets();
    test_absorb();

    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_file_transfer_packet_deframer_top: PASS");
    end else begin
      $display("tb_file_transfer_packet_deframer_top: FAIL");
    end
    $finish;
  end

endmodule
